// ----- design/acfb_pkg.sv -----
// package for the aes cfb128 byte decryptor
// types, constants, s-box and round helpers; no dependencies
package acfb_pkg;

    localparam int ByteW  = 8;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] REG_KEY0 = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_KEY1 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_KEY2 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_KEY3 = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_KLEN = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_IVH  = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_IVL  = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_OUT
    } state_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
        8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
        8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
        8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
        8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
        8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
        8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
        8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
        8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
        8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
        8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
        8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
        8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
        8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
        8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
        8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
        8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
        8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
        8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
        8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
        8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
        8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
        8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
        8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
        8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
        8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
        8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
        8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
        8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
        8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
        8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
        8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
        8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
        8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
        8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
        8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
        8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
        8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
        8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
        8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
        8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
        8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
        8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
        8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
        8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
        8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
        8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
        8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
        8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
        8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
        8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
        8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
        8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
        8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
        8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
        8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
        8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
        8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
        8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
        8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
        8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
        8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
        8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
        8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
        8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // one column of mixcolumns, byte 0 in the top bits
    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3, al;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        al = a0 ^ a1 ^ a2 ^ a3;
        return {a0 ^ al ^ xt(a0 ^ a1), a1 ^ al ^ xt(a1 ^ a2),
                a2 ^ al ^ xt(a2 ^ a3), a3 ^ al ^ xt(a3 ^ a0)};
    endfunction

endpackage

// ----- design/acfb_if.sv -----
// valid/ready channel and configuration write channel
// uses acfb_pkg for widths
interface acfb_in_if import acfb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] cipher_byte;
    logic             restart;
    modport source (output valid, cipher_byte, restart, input ready);
    modport sink (input valid, cipher_byte, restart, output ready);
endinterface

interface acfb_out_if import acfb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] plain_byte;
    logic             block_end;
    modport source (output valid, plain_byte, block_end, input ready);
    modport sink (input valid, plain_byte, block_end, output ready);
endinterface

interface acfb_cfg_if import acfb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/aes_cfb128_byte_decrypt.sv -----
// aes cfb128 byte-stream decryptor, top level
// depends on acfb_pkg and the channel interfaces in acfb_if.sv
//
// One ciphertext byte in, one plaintext byte out. A byte at block position
// zero runs one AES encryption of the feedback block through a single shared
// round unit: one round per cycle with the round key generated on the fly,
// four key words per cycle. The other fifteen bytes skip the rounds and take
// their keystream byte from the stored block.
// The input is taken again in the cycle after the result item is accepted.
module aes_cfb128_byte_decrypt
    import acfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    acfb_in_if.sink     in_ch,
    acfb_out_if.source  out_ch,
    acfb_cfg_if.sink    cfg
);

    logic [255:0] key_reg;
    logic [1:0]   klen_reg;
    logic [127:0] iv_reg;
    logic [127:0] fb_reg, fb_next;
    logic [127:0] ks_reg, ks_next;
    logic [127:0] st_reg, st_next;
    logic [3:0]   pos_reg, pos_next;
    logic [3:0]   rnd_reg, rnd_next;
    // rolling key window of nk words (up to 8), word 0 oldest
    logic [31:0]  kw_reg [8];
    logic [31:0]  kw_next [8];
    logic [7:0]   rcon_reg, rcon_next;
    logic [2:0]   rcsel_reg, rcsel_next;
    logic [7:0]   cb_reg, cb_next;
    logic [7:0]   pt_reg, pt_next;
    logic         end_reg, end_next;
    state_t       state_reg, state_next;

    logic [3:0]   nk, nr;
    logic [31:0]  rk [4];
    logic [127:0] sr, mc;
    logic [127:0] rkey;
    logic         in_acc, out_acc;

    assign cfg.ready = 1'b1;
    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;
    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = (state_reg == ST_OUT);
    assign out_ch.plain_byte = pt_reg;
    assign out_ch.block_end  = end_reg;

    assign nk = (klen_reg == 2'd0) ? 4'd4 : (klen_reg == 2'd1) ? 4'd6 : 4'd8;
    assign nr = nk + 4'd6;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            klen_reg <= '0;
            iv_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
            REG_KEY0: key_reg[255:192] <= cfg.data;
            REG_KEY1: key_reg[191:128] <= cfg.data;
            REG_KEY2: key_reg[127:64]  <= cfg.data;
            REG_KEY3: key_reg[63:0]    <= cfg.data;
            REG_KLEN: klen_reg <= cfg.data[1:0];
            REG_IVH:  iv_reg[127:64] <= cfg.data;
            REG_IVL:  iv_reg[63:0]   <= cfg.data;
            default: ;
            endcase
        end
    end

    // next four key words, produced serially from the window; the window
    // slides by four words per round
    always_comb
    begin
        logic [31:0] t;
        logic [7:0]  rcv;
        logic [2:0]  rs;
        logic [31:0] win [8];
        for (int k = 0; k < 8; k++) win[k] = kw_reg[k];
        rcv = rcon_reg; rs = rcsel_reg;
        for (int j = 0; j < 4; j++)
        begin
            t = win[3'(nk - 4'd1)];
            if (rs == 3'd0)
                t = sub_word({t[23:0], t[31:24]}) ^ {rcv, 24'h0};
            else if (nk == 4'd8 && rs == 3'd4)
                t = sub_word(t);
            rk[j] = win[0] ^ t;
            for (int k = 0; k < 7; k++) win[k] = win[k+1];
            win[3'(nk - 4'd1)] = rk[j];
            if (rs == 3'(nk - 4'd1))
            begin
                rs = 3'd0;
                rcv = xt(rcv);
            end
            else
                rs = rs + 3'd1;
        end
        for (int k = 0; k < 8; k++) kw_next[k] = win[k];
        rcon_next = rcv; rcsel_next = rs;
    end

    // shiftrows after subbytes, then mixcolumns; round key is the head of
    // the slid window
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                sr[127-8*(4*c+r) -: 8] = sbox(st_reg[127-8*(4*((c+r)%4)+r) -: 8]);
        for (int c = 0; c < 4; c++)
            mc[127-32*c -: 32] = mix_col(sr[127-32*c -: 32]);
        rkey = {kw_next[0], kw_next[1], kw_next[2], kw_next[3]};
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
        ST_IDLE:  if (in_acc) state_next = (in_ch.restart || pos_reg == 4'd0) ?
                                            ST_ROUND : ST_OUT;
        ST_ROUND: if (rnd_reg == nr) state_next = ST_OUT;
        ST_OUT:   if (out_acc) state_next = ST_IDLE;
        default:  state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        logic [3:0]   p;
        logic [127:0] fb0, ks1;
        fb_next = fb_reg; ks_next = ks_reg; st_next = st_reg;
        pos_next = pos_reg; rnd_next = rnd_reg; cb_next = cb_reg;
        pt_next = pt_reg; end_next = end_reg;
        p = pos_reg; fb0 = fb_reg; ks1 = ks_reg;
        case (state_reg)
        ST_IDLE:
        begin
            if (in_acc)
            begin
                cb_next = in_ch.cipher_byte;
                if (in_ch.restart)
                begin
                    fb0 = iv_reg;
                    p = 4'd0;
                end
                fb_next = fb0;
                pos_next = p;
                rnd_next = 4'd1;
                if (p == 4'd0)
                    st_next = fb0 ^ key_reg[255:128];
                else
                begin
                    pt_next = ks_reg[127-8*p -: 8] ^ in_ch.cipher_byte;
                    ks1[127-8*p -: 8] = in_ch.cipher_byte;
                    ks_next = ks1;
                    end_next = (p == 4'd15);
                    if (p == 4'd15) fb_next = ks1;
                    pos_next = p + 4'd1;
                end
            end
        end
        ST_ROUND:
        begin
            rnd_next = rnd_reg + 4'd1;
            st_next = ((rnd_reg == nr) ? sr : mc) ^ rkey;
            if (rnd_reg == nr)
            begin
                ks1 = sr ^ rkey;
                pt_next = ks1[127:120] ^ cb_reg;
                ks1[127:120] = cb_reg;
                ks_next = ks1;
                end_next = 1'b0;
                pos_next = 4'd1;
            end
        end
        default: ;
        endcase
    end

    // state, position, feedback and key window registers: window loaded at start, advanced each round
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            fb_reg    <= '0;
            rcon_reg  <= '0;
            rcsel_reg <= '0;
            for (int k = 0; k < 8; k++) kw_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            fb_reg    <= fb_next;
            if (state_reg == ST_IDLE && in_acc)
            begin
                // window starts at key word 0
                for (int k = 0; k < 8; k++) kw_reg[k] <= key_reg[255-32*k -: 32];
                rcon_reg <= 8'h01;
                rcsel_reg <= 3'd0;
            end
            else if (state_reg == ST_ROUND)
            begin
                for (int k = 0; k < 8; k++) kw_reg[k] <= kw_next[k];
                rcon_reg  <= rcon_next;
                rcsel_reg <= rcsel_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ks_reg  <= ks_next;
        st_reg  <= st_next;
        rnd_reg <= rnd_next;
        cb_reg  <= cb_next;
        pt_reg  <= pt_next;
        end_reg <= end_next;
    end

endmodule
